/* rtl/core/ftdr_pkg.sv */
// shared types and constants for the forwarding table with default route
`timescale 1ns / 1ps
`default_nettype none

package ftdr_pkg;

    // table geometry
    localparam int TABLE_DEPTH = 16;
    localparam int IDX_W       = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

    // field widths
    localparam int ADDR_W     = 16;
    localparam int PORT_W     = 4;
    localparam int DELAY_W    = 16;
    localparam int ENTRY_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    // request actions
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_LOOKUP = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_PORT  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_DELAY = 1'b1;

    // controller states
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_FINISH
    } ftdr_state_t;

    // controller to datapath commands
    typedef struct packed {
        logic load;
        logic issue;
        logic finish;
    } ftdr_cmd_t;

    // datapath to controller status
    typedef struct packed {
        logic match;
        logic scan_end;
        logic cmp_pend;
    } ftdr_sts_t;

endpackage

`default_nettype wire

/* rtl/core/ftdr_ctrl.sv */
// controller state machine for the forwarding table search and update
`timescale 1ns / 1ps
`default_nettype none

module ftdr_ctrl
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire ftdr_pkg::ftdr_sts_t sts,
    output ftdr_pkg::ftdr_cmd_t     cmd,
    output logic                    busy
);
    import ftdr_pkg::*;

    ftdr_state_t state_reg;
    ftdr_state_t state_next;

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    cmd.load   = 1'b1;
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN:
            begin
                if (sts.match)
                begin
                    state_next = ST_FINISH;
                end
                else if (sts.scan_end && !sts.cmp_pend)
                begin
                    state_next = ST_FINISH;
                end
                else
                begin
                    cmd.issue = !sts.scan_end;
                end
            end
            ST_FINISH:
            begin
                cmd.finish = 1'b1;
                state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != ST_IDLE);

endmodule

`default_nettype wire

/* rtl/core/ftdr_dp.sv */
// datapath: entry memories, scan pointer, compare, config and result registers
`timescale 1ns / 1ps
`default_nettype none

module ftdr_dp
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire ftdr_pkg::ftdr_cmd_t               cmd,
    output ftdr_pkg::ftdr_sts_t                    sts,
    input  wire logic                              action,
    input  wire logic [ftdr_pkg::ADDR_W-1:0]       address,
    input  wire logic [ftdr_pkg::PORT_W-1:0]       port,
    input  wire logic [ftdr_pkg::DELAY_W-1:0]      delay,
    input  wire logic                              cfg_we,
    input  wire logic [ftdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ftdr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   done,
    output logic                                   accepted,
    output logic                                   hit,
    output logic [ftdr_pkg::PORT_W-1:0]            next_port,
    output logic [ftdr_pkg::DELAY_W-1:0]           next_delay,
    output logic [ftdr_pkg::ENTRY_W-1:0]           entry_count
);
    import ftdr_pkg::*;

    // entry memories
    logic [ADDR_W-1:0]  dest_mem  [TABLE_DEPTH];
    logic [PORT_W-1:0]  port_mem  [TABLE_DEPTH];
    logic [DELAY_W-1:0] delay_mem [TABLE_DEPTH];

    // latched request
    logic               req_action_reg;
    logic [ADDR_W-1:0]  req_addr_reg;
    logic [PORT_W-1:0]  req_port_reg;
    logic [DELAY_W-1:0] req_delay_reg;

    // scan state
    logic [CNT_W-1:0]   idx_reg;
    logic               cmp_vld_reg;
    logic [ADDR_W-1:0]  rd_dest_reg;
    logic [PORT_W-1:0]  rd_port_reg;
    logic [DELAY_W-1:0] rd_delay_reg;
    logic               found_reg;
    logic [PORT_W-1:0]  fnd_port_reg;
    logic [DELAY_W-1:0] fnd_delay_reg;

    // table fill and configuration
    logic [CNT_W-1:0]   cnt_reg;
    logic [CNT_W-1:0]   cnt_next;
    logic [PORT_W-1:0]  def_port_reg;
    logic [DELAY_W-1:0] def_delay_reg;

    // result registers
    logic               res_vld_reg;
    logic               acc_reg;
    logic               hit_reg;
    logic [PORT_W-1:0]  nport_reg;
    logic [DELAY_W-1:0] ndelay_reg;
    logic [ENTRY_W-1:0] entry_reg;

    logic match;
    logic ins_ok;

    // compare the entry read last cycle
    assign match = cmp_vld_reg && (rd_dest_reg == req_addr_reg);

    assign sts.match    = match;
    assign sts.scan_end = (idx_reg == cnt_reg);
    assign sts.cmp_pend = cmp_vld_reg;

    // insert goes through when the address is new and there is room
    assign ins_ok = (req_action_reg == ACT_INSERT) && !found_reg &&
                    (cnt_reg != CNT_W'(TABLE_DEPTH));
    assign cnt_next = ins_ok ? (cnt_reg + CNT_W'(1)) : cnt_reg;

    // request capture
    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_action_reg <= action;
            req_addr_reg   <= address;
            req_port_reg   <= port;
            req_delay_reg  <= delay;
        end
    end

    // scan pointer and compare valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg     <= '0;
            cmp_vld_reg <= 1'b0;
            found_reg   <= 1'b0;
        end
        else
        begin
            if (cmd.load)
            begin
                idx_reg <= '0;
            end
            else if (cmd.issue)
            begin
                idx_reg <= idx_reg + CNT_W'(1);
            end
            cmp_vld_reg <= cmd.issue;
            if (cmd.load)
            begin
                found_reg <= 1'b0;
            end
            else if (match)
            begin
                found_reg <= 1'b1;
            end
        end
    end

    // memory read port, one entry per cycle
    always_ff @(posedge clk)
    begin
        if (cmd.issue)
        begin
            rd_dest_reg  <= dest_mem[idx_reg[IDX_W-1:0]];
            rd_port_reg  <= port_mem[idx_reg[IDX_W-1:0]];
            rd_delay_reg <= delay_mem[idx_reg[IDX_W-1:0]];
        end
        if (match)
        begin
            fnd_port_reg  <= rd_port_reg;
            fnd_delay_reg <= rd_delay_reg;
        end
    end

    // memory write port, append at the fill count
    always_ff @(posedge clk)
    begin
        if (cmd.finish && ins_ok)
        begin
            dest_mem[cnt_reg[IDX_W-1:0]]  <= req_addr_reg;
            port_mem[cnt_reg[IDX_W-1:0]]  <= req_port_reg;
            delay_mem[cnt_reg[IDX_W-1:0]] <= req_delay_reg;
        end
    end

    // fill count and default route registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg       <= '0;
            def_port_reg  <= '0;
            def_delay_reg <= '0;
        end
        else
        begin
            if (cmd.finish)
            begin
                cnt_reg <= cnt_next;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_DEFAULT_PORT:  def_port_reg  <= cfg_data[PORT_W-1:0];
                    REG_DEFAULT_DELAY: def_delay_reg <= cfg_data[DELAY_W-1:0];
                    default:           ;
                endcase
            end
        end
    end

    // result registers, loaded at finish; done is strobed for one cycle
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_vld_reg <= 1'b0;
            acc_reg     <= 1'b0;
            hit_reg     <= 1'b0;
            nport_reg   <= '0;
            ndelay_reg  <= '0;
            entry_reg   <= '0;
        end
        else
        begin
            res_vld_reg <= cmd.finish;
            if (cmd.finish)
            begin
                acc_reg   <= ins_ok;
                hit_reg   <= (req_action_reg == ACT_LOOKUP) && found_reg;
                entry_reg <= ENTRY_W'(cnt_next);
                if (req_action_reg == ACT_LOOKUP)
                begin
                    nport_reg  <= found_reg ? fnd_port_reg  : def_port_reg;
                    ndelay_reg <= found_reg ? fnd_delay_reg : def_delay_reg;
                end
                else
                begin
                    nport_reg  <= '0;
                    ndelay_reg <= '0;
                end
            end
        end
    end

    assign done        = res_vld_reg;
    assign accepted    = acc_reg;
    assign hit         = hit_reg;
    assign next_port   = nport_reg;
    assign next_delay  = ndelay_reg;
    assign entry_count = entry_reg;

endmodule

`default_nettype wire

/* rtl/core/forwarding_table_default_route.sv */
// top level of the exact-match forwarding table with default route
//
// usage:
//   a request is taken on the rising edge where start is high and busy is low;
//   action selects insert (append a new address with its port and delay) or
//   lookup (return the stored port and delay, or the defaults on a miss).
//   each request gives exactly one result, shown for one cycle with done high;
//   the receiver cannot stall, so results are never held back.
//   the user must write default port and delay via cfg_we, cfg_index, cfg_data
//   only while the block is idle, unenforced; index 0 port, index 1 delay.
// search and handoff:
//   the search reads one stored entry per cycle from the entry memories and
//   compares it in the following cycle, stopping at the first match. busy
//   drops with the result, so the next request may start in the cycle done
//   is shown.
// reset:
//   rst_n clears the entry count, the defaults and the controller; the entry
//   memories are not cleared, entries past the count are never read.
`timescale 1ns / 1ps
`default_nettype none

module forwarding_table_default_route
(
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    output logic                                   busy,
    input  wire logic                              action,
    input  wire logic [ftdr_pkg::ADDR_W-1:0]       address,
    input  wire logic [ftdr_pkg::PORT_W-1:0]       port,
    input  wire logic [ftdr_pkg::DELAY_W-1:0]      delay,
    input  wire logic                              cfg_we,
    input  wire logic [ftdr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [ftdr_pkg::CFG_DATA_W-1:0]   cfg_data,
    output logic                                   done,
    output logic                                   accepted,
    output logic                                   hit,
    output logic [ftdr_pkg::PORT_W-1:0]            next_port,
    output logic [ftdr_pkg::DELAY_W-1:0]           next_delay,
    output logic [ftdr_pkg::ENTRY_W-1:0]           entry_count
);
    import ftdr_pkg::*;

    ftdr_cmd_t cmd;
    ftdr_sts_t sts;
    logic      start_ok;

    // a request is only taken while idle
    assign start_ok = start && !busy;

    // controller
    ftdr_ctrl u_ctrl
    (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start_ok),
        .sts   (sts),
        .cmd   (cmd),
        .busy  (busy)
    );

    // datapath
    ftdr_dp u_dp
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (cmd),
        .sts         (sts),
        .action      (action),
        .address     (address),
        .port        (port),
        .delay       (delay),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .accepted    (accepted),
        .hit         (hit),
        .next_port   (next_port),
        .next_delay  (next_delay),
        .entry_count (entry_count)
    );

endmodule

`default_nettype wire

/* rtl/core/ftdr_chk.sv */
// port-level checker for the forwarding table, bound to the top level
`timescale 1ns / 1ps
`default_nettype none

module ftdr_chk
(
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic                         busy,
    input  wire logic                         done,
    input  wire logic                         accepted,
    input  wire logic                         hit,
    input  wire logic [ftdr_pkg::ENTRY_W-1:0] entry_count
);
    import ftdr_pkg::*;

    // a request taken while idle makes the block busy
    a_start_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |=> busy)
        else $error("request accepted but block not busy");

    // a result only follows a busy cycle
    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(busy))
        else $error("result without a request in progress");

    // insert success and lookup hit never come together
    a_acc_hit: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(accepted && hit))
        else $error("accepted and hit both set");

    // an accepted insert grows the count by one
    a_count_grow: assert property (@(posedge clk) disable iff (!rst_n)
        done && accepted |-> entry_count == ENTRY_W'($past(entry_count) + 1'b1))
        else $error("entry count did not grow on insert");

    // anything else leaves the count alone
    a_count_keep: assert property (@(posedge clk) disable iff (!rst_n)
        done && !accepted |-> $stable(entry_count))
        else $error("entry count changed without an insert");

endmodule

bind forwarding_table_default_route ftdr_chk u_chk (.*);

`default_nettype wire

/* test/tb_forwarding_table_default_route.sv */
// self-checking testbench for the forwarding table with default route
`timescale 1ns / 1ps

module tb_forwarding_table_default_route;
    import ftdr_pkg::*;

    localparam int CYCLE_LIMIT      = 200000;
    localparam int PHASES           = 5;
    localparam int RANDOM_PER_PHASE = 225;
    localparam int DRAIN_CYCLES     = 25;
    localparam int MAX_REPORTS      = 10;

    // one request as presented on the input ports
    typedef struct packed {
        logic               act;
        logic [ADDR_W-1:0]  addr;
        logic [PORT_W-1:0]  port;
        logic [DELAY_W-1:0] delay;
    } route_req_t;

    // one result as shown on the output ports
    typedef struct packed {
        logic               accepted;
        logic               hit;
        logic [PORT_W-1:0]  next_port;
        logic [DELAY_W-1:0] next_delay;
        logic [ENTRY_W-1:0] entry_count;
    } route_res_t;

    // shadow copy of the table and defaults, with the results still to come
    class route_checker;
        logic [ADDR_W-1:0]  dest_tab [TABLE_DEPTH];
        logic [PORT_W-1:0]  port_tab [TABLE_DEPTH];
        logic [DELAY_W-1:0] delay_tab [TABLE_DEPTH];
        logic [ENTRY_W-1:0] used = '0;
        logic [PORT_W-1:0]  dflt_port = '0;
        logic [DELAY_W-1:0] dflt_delay = '0;
        route_res_t         pending_routes [$];
        int                 mismatches = 0;

        function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            if (idx == REG_DEFAULT_PORT)
                dflt_port = data[PORT_W-1:0];
            else if (idx == REG_DEFAULT_DELAY)
                dflt_delay = data[DELAY_W-1:0];
        endfunction

        // first stored slot holding addr, in insertion order, or -1
        function int find_slot(logic [ADDR_W-1:0] addr);
            for (int i = 0; i < TABLE_DEPTH; i++)
            begin
                if (i < used && dest_tab[i] == addr)
                    return i;
            end
            return -1;
        endfunction

        // predict the route result of an accepted request
        function void note_request(route_req_t rq);
            route_res_t r;
            int         slot;
            r    = '0;
            slot = find_slot(rq.addr);
            if (rq.act == ACT_INSERT)
            begin
                // append unless full or already present
                if (used < TABLE_DEPTH && slot < 0)
                begin
                    dest_tab[used]  = rq.addr;
                    port_tab[used]  = rq.port;
                    delay_tab[used] = rq.delay;
                    used            = used + 1'b1;
                    r.accepted      = 1'b1;
                end
            end
            else if (slot >= 0)
            begin
                r.hit        = 1'b1;
                r.next_port  = port_tab[slot];
                r.next_delay = delay_tab[slot];
            end
            else
            begin
                r.next_port  = dflt_port;
                r.next_delay = dflt_delay;
            end
            r.entry_count = used;
            pending_routes.push_back(r);
        endfunction

        function void report(string what, route_res_t want, route_res_t got);
            mismatches++;
            if (mismatches <= MAX_REPORTS)
            begin
                $write("%s: expected acc=%0d hit=%0d port=%0h delay=%0h count=%0d, ",
                       what, want.accepted, want.hit, want.next_port, want.next_delay,
                       want.entry_count);
                $display("got acc=%0d hit=%0d port=%0h delay=%0h count=%0d",
                         got.accepted, got.hit, got.next_port, got.next_delay,
                         got.entry_count);
            end
        endfunction

        // compare one shown result with the oldest prediction
        function void check_route(route_res_t got);
            route_res_t want;
            if (pending_routes.size() == 0)
            begin
                report("unexpected result", '0, got);
                return;
            end
            want = pending_routes.pop_front();
            if (got !== want)
                report("result mismatch", want, got);
        endfunction
    endclass

    logic                  clk       = 1'b0;
    logic                  rst_n     = 1'b0;
    logic                  start     = 1'b0;
    logic                  action    = 1'b0;
    logic [ADDR_W-1:0]     address   = '0;
    logic [PORT_W-1:0]     port      = '0;
    logic [DELAY_W-1:0]    delay     = '0;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    logic                  busy;
    logic                  done;
    logic                  accepted;
    logic                  hit;
    logic [PORT_W-1:0]     next_port;
    logic [DELAY_W-1:0]    next_delay;
    logic [ENTRY_W-1:0]    entry_count;
    int unsigned           cycle_count = 0;

    route_checker sb = new();

    forwarding_table_default_route u_top
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .start       (start),
        .busy        (busy),
        .action      (action),
        .address     (address),
        .port        (port),
        .delay       (delay),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data),
        .done        (done),
        .accepted    (accepted),
        .hit         (hit),
        .next_port   (next_port),
        .next_delay  (next_delay),
        .entry_count (entry_count)
    );

    // clock
    always #1 clk = ~clk;

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb_forwarding_table_default_route: errors");
            $finish;
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (rst_n && done)
            sb.check_route(route_res_t'({accepted, hit, next_port, next_delay, entry_count}));
    end

    function automatic route_req_t make_req(logic act, logic [ADDR_W-1:0] addr,
                                            logic [PORT_W-1:0] prt, logic [DELAY_W-1:0] dly);
        route_req_t rq;
        rq.act   = act;
        rq.addr  = addr;
        rq.port  = prt;
        rq.delay = dly;
        return rq;
    endfunction

    // mostly stored addresses or one bit away from one, the rest anywhere
    function automatic route_req_t random_request();
        route_req_t rq;
        int         pick;
        rq.act   = 1'($urandom_range(1));
        rq.port  = 4'($urandom);
        rq.delay = 16'($urandom);
        pick     = $urandom_range(99);
        if (sb.used == 0 || pick < 35)
            rq.addr = 16'($urandom);
        else if (pick < 55)
            rq.addr = sb.dest_tab[$urandom_range(sb.used - 1)] ^
                      (16'h0001 << $urandom_range(15));
        else
            rq.addr = sb.dest_tab[$urandom_range(sb.used - 1)];
        return rq;
    endfunction

    // optional idle cycles, then hold the request until busy is low
    task automatic issue(input route_req_t rq, input int idle_pct);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start   <= 1'b1;
        action  <= rq.act;
        address <= rq.addr;
        port    <= rq.port;
        delay   <= rq.delay;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        sb.note_request(rq);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        sb.set_register(idx, data);
    endtask

    task automatic wait_idle();
        while (sb.pending_routes.size() != 0)
            @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // stimulus
    initial
    begin
        logic [PORT_W-1:0]  phase_port [PHASES];
        logic [DELAY_W-1:0] phase_delay [PHASES];
        int                 idle_pct [PHASES];
        phase_port  = '{4'h0, 4'hf, 4'h0, 4'h0, 4'hf};
        phase_delay = '{16'h0000, 16'hffff, 16'h0000, 16'hffff, 16'h0000};
        idle_pct    = '{0, 80, 21, 0, 80};
        phase_port[2]  = 4'($urandom);
        phase_delay[2] = 16'($urandom);

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // defaults for the directed tests
        write_reg(REG_DEFAULT_PORT, {12'($urandom), 4'ha});
        write_reg(REG_DEFAULT_DELAY, 16'h5a5a);
        cfg_we <= 1'b0;

        // lookup on an empty table
        issue(make_req(ACT_LOOKUP, 16'hffff, 4'h3, 16'h0101), 0);
        // lowest and highest field values
        issue(make_req(ACT_INSERT, 16'h0000, 4'h0, 16'h0000), 0);
        issue(make_req(ACT_INSERT, 16'hffff, 4'hf, 16'hffff), 0);
        // duplicate address is rejected
        issue(make_req(ACT_INSERT, 16'h0000, 4'h5, 16'h0007), 0);
        issue(make_req(ACT_LOOKUP, 16'h0000, 4'hf, 16'hffff), 0);
        issue(make_req(ACT_LOOKUP, 16'hffff, 4'h0, 16'h0000), 0);
        issue(make_req(ACT_LOOKUP, 16'h0001, 4'h0, 16'h0000), 0);
        // fill the table
        for (int i = 0; i < TABLE_DEPTH - 2; i++)
            issue(make_req(ACT_INSERT, 16'h0001 << i, 4'(i + 1), 16'($urandom)), 0);
        // insert into a full table, new and duplicate
        issue(make_req(ACT_INSERT, 16'h1234, 4'h9, 16'h4321), 0);
        issue(make_req(ACT_INSERT, 16'hffff, 4'h1, 16'h0001), 0);
        // hit on the last slot and miss after a full scan
        issue(make_req(ACT_LOOKUP, 16'h2000, 4'h0, 16'h0000), 0);
        issue(make_req(ACT_LOOKUP, 16'h1234, 4'h0, 16'h0000), 0);

        // random phases, each setting the defaults and the idle rate
        for (int ph = 0; ph < PHASES; ph++)
        begin
            start <= 1'b0;
            wait_idle();
            write_reg(REG_DEFAULT_PORT, {12'($urandom), phase_port[ph]});
            write_reg(REG_DEFAULT_DELAY, phase_delay[ph]);
            cfg_we <= 1'b0;
            repeat (RANDOM_PER_PHASE)
                issue(random_request(), idle_pct[ph]);
        end

        // drain
        start <= 1'b0;
        wait_idle();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending_routes.size() == 0)
            $display("tb_forwarding_table_default_route: clean");
        else
            $display("tb_forwarding_table_default_route: errors");
        $finish;
    end

endmodule

/* filelist.f */
rtl/core/ftdr_pkg.sv
rtl/core/ftdr_ctrl.sv
rtl/core/ftdr_dp.sv
rtl/core/forwarding_table_default_route.sv
rtl/core/ftdr_chk.sv
test/tb_forwarding_table_default_route.sv
